### design/tbpp_pkg.sv
`timescale 1ns / 1ps

package tbpp_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 64;

    localparam int LINES_PER_PAGE = 8;
    localparam int LINE_W         = $clog2(LINES_PER_PAGE);
    localparam int MAX_PAGES      = (MAX_HEIGHT + LINES_PER_PAGE - 1) / LINES_PER_PAGE;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int PAGE_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int WEFF_W  = $clog2(MAX_WIDTH + 1);
    localparam int HEFF_W  = $clog2(MAX_HEIGHT + 1);
    localparam int TOT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int PIX_W   = $clog2(MAX_WIDTH * MAX_PAGES * LINES_PER_PAGE);
    localparam int WCMP_W  = WEFF_W + 1;
    localparam int HCMP_W  = HEFF_W + 1;
    localparam int XCMP_W  = ((PIX_W > TOT_W) ? PIX_W : TOT_W) + 1;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
    localparam logic [7:0] COL_HIGH_CMD  = 8'h10;
    localparam logic [7:0] COL_LOW_CMD   = 8'h00;

    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_WIDTH     = 2'd1;
    localparam logic [1:0] CFG_HEIGHT    = 2'd2;

    localparam logic [1:0] STEP_FIRST = 2'd0;
    localparam logic [1:0] STEP_MID   = 2'd1;
    localparam logic [1:0] STEP_LAST  = 2'd2;

    typedef struct packed {
        logic       is_page;
        logic [7:0] value;
        logic       frame_end;
    } t_evt;

endpackage

### design/tbpp_front.sv
`timescale 1ns / 1ps

module tbpp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_push,
    input  logic [7:0]         i_pixel_value,
    input  logic               i_q_full,
    output logic               o_evt_push,
    output tbpp_pkg::t_evt     o_evt
);
    import tbpp_pkg::*;

    logic [7:0]        r_threshold;
    logic [7:0]        r_width;
    logic [6:0]        r_height;
    logic [7:0]        r_packed;
    logic [LINE_W-1:0] r_line;
    logic [COL_W-1:0]  r_col;
    logic [PAGE_W-1:0] r_page;
    logic [PIX_W-1:0]  r_pix;

    logic [7:0]        n_packed;
    logic [LINE_W-1:0] n_line;
    logic [COL_W-1:0]  n_col;
    logic [PAGE_W-1:0] n_page;
    logic [PIX_W-1:0]  n_pix;

    logic [WEFF_W-1:0] w_eff;
    logic [HEFF_W-1:0] h_eff;
    logic [HCMP_W-1:0] pages;
    logic [TOT_W-1:0]  total;
    logic              accept;
    logic              page_start;
    logic              col_done;
    logic              lit;
    logic              last_col;
    logic              last_page;
    logic              frame_done;
    logic [7:0]        col_byte;

    always_comb begin
        if (r_width == 8'd0) begin
            w_eff = WEFF_W'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_eff = WEFF_W'(MAX_WIDTH);
        end else begin
            w_eff = WEFF_W'(r_width);
        end
        if (r_height == 7'd0) begin
            h_eff = HEFF_W'(1);
        end else if (int'(r_height) > MAX_HEIGHT) begin
            h_eff = HEFF_W'(MAX_HEIGHT);
        end else begin
            h_eff = HEFF_W'(r_height);
        end
    end

    assign pages = (HCMP_W'(h_eff) + HCMP_W'(LINES_PER_PAGE - 1)) >> LINE_W;
    assign total = TOT_W'(w_eff) * TOT_W'(h_eff);

    assign accept     = i_push && !i_q_full;
    assign page_start = (r_line == '0) && (r_col == '0);
    assign col_done   = (r_line == LINE_W'(LINES_PER_PAGE - 1));
    assign lit        = (XCMP_W'(r_pix) < XCMP_W'(total)) && (i_pixel_value > r_threshold);
    assign col_byte   = r_packed | (8'(lit) << r_line);
    assign last_col   = (WCMP_W'(r_col) + WCMP_W'(1)) >= WCMP_W'(w_eff);
    assign last_page  = (HCMP_W'(r_page) + HCMP_W'(1)) >= pages;
    assign frame_done = last_col && last_page;

    always_comb begin
        n_packed = col_byte;
        n_line   = r_line + LINE_W'(1);
        n_col    = r_col;
        n_page   = r_page;
        n_pix    = r_pix + PIX_W'(1);
        if (col_done) begin
            n_packed = '0;
            n_line   = '0;
            if (frame_done) begin
                n_col  = '0;
                n_page = '0;
                n_pix  = '0;
            end else if (last_col) begin
                n_col  = '0;
                n_page = r_page + PAGE_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_comb begin
        o_evt_push      = accept && (page_start || col_done);
        o_evt.is_page   = page_start;
        o_evt.value     = page_start ? (PAGE_CMD_BASE + 8'(r_page)) : col_byte;
        o_evt.frame_end = !page_start && frame_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= 8'd0;
            r_width     <= 8'd128;
            r_height    <= 7'd64;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_WIDTH:     r_width     <= i_cfg_data;
                CFG_HEIGHT:    r_height    <= i_cfg_data[6:0];
                default:       r_threshold <= r_threshold;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packed <= '0;
            r_line   <= '0;
            r_col    <= '0;
            r_page   <= '0;
            r_pix    <= '0;
        end else if (accept) begin
            r_packed <= n_packed;
            r_line   <= n_line;
            r_col    <= n_col;
            r_page   <= n_page;
            r_pix    <= n_pix;
        end
    end

`ifndef SYNTH
    a_page_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        page_start |-> (r_packed == 8'd0))
        else $error("packed bits not clear at page start");
    a_frame_end_rolls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt_push && o_evt.frame_end) |=> (r_page == '0 && r_col == '0 && r_pix == '0))
        else $error("counters did not return to zero after frame end");
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> ($stable(r_line) && $stable(r_col) && $stable(r_page)))
        else $error("counters moved without an accepted transaction");
`endif

endmodule

### design/tbpp_queue.sv
`timescale 1ns / 1ps

module tbpp_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tbpp_pkg::t_evt     i_evt,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_empty,
    output tbpp_pkg::t_evt     o_evt
);
    import tbpp_pkg::*;

    t_evt              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_evt   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count over depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == QPTR_W'(r_count))
        else $error("queue pointers disagree with count");
`endif

endmodule

### design/tbpp_back.sv
`timescale 1ns / 1ps

module tbpp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  tbpp_pkg::t_evt     i_evt,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [7:0]         o_out_byte,
    output logic               o_is_data,
    output logic               o_frame_end
);
    import tbpp_pkg::*;

    logic       r_valid;
    t_evt       r_evt;
    logic [1:0] r_step;
    logic       take;
    logic       last_step;
    logic       load;

    assign take      = r_valid && i_pop;
    assign last_step = !r_evt.is_page || (r_step == STEP_LAST);
    assign load      = (!r_valid || (take && last_step)) && !i_q_empty;
    assign o_q_pop   = load;

    always_comb begin
        o_empty     = !r_valid;
        o_is_data   = !r_evt.is_page;
        o_frame_end = !r_evt.is_page && r_evt.frame_end;
        if (!r_evt.is_page) begin
            o_out_byte = r_evt.value;
        end else begin
            case (r_step)
                STEP_FIRST: o_out_byte = r_evt.value;
                STEP_MID:   o_out_byte = COL_HIGH_CMD;
                default:    o_out_byte = COL_LOW_CMD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_evt <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= STEP_FIRST;
        end else if (load) begin
            r_valid <= 1'b1;
            r_step  <= STEP_FIRST;
        end else if (take) begin
            if (last_step) begin
                r_valid <= 1'b0;
                r_step  <= STEP_FIRST;
            end else begin
                r_step <= r_step + 2'd1;
            end
        end
    end

`ifndef SYNTH
    a_step_page_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != STEP_FIRST) |-> (r_valid && r_evt.is_page))
        else $error("command step advanced outside a page transaction");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_pop) |=> (r_valid && $stable(r_step)))
        else $error("result changed while stalled");
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> !i_q_empty)
        else $error("pop from empty event queue");
`endif

endmodule

### design/threshold_bitmap_page_packer_unit.sv
`timescale 1ns / 1ps

// Grayscale-to-OLED page packer. Each pushed 8-bit pixel is compared with the
// threshold and packed LSB first into column bytes; every page begins with the
// three command bytes 0xB0+page, 0x10, 0x00. Accepts one pixel per cycle
// while the event queue is not full; the output side delivers one byte per
// cycle while events are queued. An event from an accepted pixel is written
// into the event queue and then into the back-end register on the outputs.
// The front counter/threshold logic feeds a four-entry event queue, and the
// back end expands each page event into three command bytes over three pops,
// so full rises only while that queue is full. Configuration writes are
// always ready and take effect on the next cycle.
module threshold_bitmap_page_packer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_pixel_value,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_out_byte,
    output logic       o_is_data,
    output logic       o_frame_end
);
    import tbpp_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_pop;
    logic evt_push;
    t_evt evt_in;
    t_evt evt_out;

    assign o_cfg_ready = 1'b1;
    assign o_full      = q_full;

    tbpp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_push        (i_push),
        .i_pixel_value (i_pixel_value),
        .i_q_full      (q_full),
        .o_evt_push    (evt_push),
        .o_evt         (evt_in)
    );

    tbpp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (evt_push),
        .i_evt   (evt_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_evt   (evt_out)
    );

    tbpp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_evt       (evt_out),
        .o_q_pop     (q_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_out_byte  (o_out_byte),
        .o_is_data   (o_is_data),
        .o_frame_end (o_frame_end)
    );

endmodule
